[hw/rtl/apool_pkg.sv]
`timescale 1ns / 1ps
package apool_pkg;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int MAX_KERNEL    = 8;
   localparam int SAMPLE_BITS   = 16;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int SLOT_BITS     = $clog2(MAX_KERNEL);
   localparam int ADDR_BITS     = SLOT_BITS + COL_BITS;
   localparam int LS_DEPTH      = MAX_KERNEL * MAX_WIDTH;
   localparam int DIM_BITS      = 11;
   localparam int KER_BITS      = 4;
   localparam int PAD_BITS      = 3;
   localparam int POS_BITS      = 12;
   localparam int CRD_BITS      = 15;
   localparam int SUM_BITS      = SAMPLE_BITS + 2 * SLOT_BITS + 1;
   localparam int AVG_BITS      = 30;
   localparam int FRAC_BITS     = 8;
   localparam int DIVR_BITS     = 8;
   localparam int CNT_BITS      = 5;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_WIDTH, REG_HEIGHT, REG_KH, REG_KW, REG_SR, REG_SC, REG_PAD, REG_MODE
   } csr_index_type;

   typedef struct packed {
      logic store;
      logic row_init;
      logic row_step;
      logic col_init;
      logic col_step;
      logic sum_init;
      logic rd_step;
      logic div_init;
      logic div_step;
      logic emit;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic row_hit;
      logic col_hit;
      logic row_more;
      logic col_more;
      logic rd_last;
      logic div_done;
      logic out_free;
   } status_type;

   // True when a window starting at padded position ps is an output position.
   function automatic logic win_ok(input logic [POS_BITS-1:0] ps,
                                   input logic [DIM_BITS-1:0] extent,
                                   input logic [KER_BITS-1:0] k,
                                   input logic [PAD_BITS-1:0] pad,
                                   input logic [KER_BITS-1:0] s,
                                   input logic ceil_on);
      logic signed [CRD_BITS-1:0] n;
      logic signed [CRD_BITS-1:0] p;
      logic signed [CRD_BITS-1:0] lim;
      logic ok;
      n   = $signed(CRD_BITS'(extent)) + $signed(CRD_BITS'({pad, 1'b0}))
            - $signed(CRD_BITS'(k));
      p   = $signed(CRD_BITS'(ps));
      lim = $signed(CRD_BITS'(extent)) + $signed(CRD_BITS'(pad));
      if (n < 0) begin
         ok = 1'b0;
      end else if (ceil_on) begin
         ok = (p < n + $signed(CRD_BITS'(s))) && (p < lim);
      end else begin
         ok = (p <= n);
      end
      return ok;
   endfunction

endpackage

[hw/rtl/apool_ifs.sv]
`timescale 1ns / 1ps
interface apool_req_if import apool_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface apool_rsp_if import apool_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [AVG_BITS-1:0] average;
   logic                       last_of_burst;
   logic                       last_of_plane;
   modport source (output valid, output average, output last_of_burst,
                   output last_of_plane, input ready);
   modport sink   (input valid, input average, input last_of_burst,
                   input last_of_plane, output ready);
endinterface

[hw/rtl/apool_ram.sv]
`timescale 1ns / 1ps
module apool_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hw/rtl/apool_ctrl.sv]
`timescale 1ns / 1ps
module apool_ctrl import apool_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_ROW, S_COL, S_READ, S_DRAIN, S_DIVINIT, S_DIV, S_EMIT, S_NEXT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.store    = 1'b1;
               cmd.row_init = 1'b1;
               state_in     = S_ROW;
            end
         end
         S_ROW: begin
            if (status.row_hit) begin
               cmd.col_init = 1'b1;
               state_in     = S_COL;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_COL: begin
            if (status.col_hit) begin
               cmd.sum_init = 1'b1;
               state_in     = S_READ;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_READ: begin
            cmd.rd_step = 1'b1;
            if (status.rd_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DIVINIT;
         end
         S_DIVINIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.col_more) begin
                  cmd.col_step = 1'b1;
                  state_in     = S_COL;
               end else if (status.row_more) begin
                  cmd.row_step = 1'b1;
                  state_in     = S_ROW;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            cmd.advance = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_accept_drop: assert property (@(posedge clock) disable iff (reset)
      accept |=> !ready_ff) else $error("ready held after transfer");
   a_div_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && status.div_done) |=> state_ff == S_EMIT)
      else $error("divide did not lead to emit");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free) else $error("emit into full output");
`endif
endmodule

[hw/rtl/apool_dp.sv]
`timescale 1ns / 1ps
module apool_dp import apool_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [CSR_IDX_BITS-1:0]        csr_index,
   input  logic [CSR_DATA_BITS-1:0]       csr_data,
   input  logic signed [SAMPLE_BITS-1:0]  sample,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic signed [AVG_BITS-1:0]     rsp_average,
   output logic                           rsp_last_of_burst,
   output logic                           rsp_last_of_plane
);
   logic [DIM_BITS-1:0] w_ff, h_ff;
   logic [KER_BITS-1:0] kh_ff, kw_ff, sr_ff, sc_ff;
   logic [6:0]          pad_ff;
   logic [15:0]         mode_ff;

   logic [DIM_BITS-1:0] img_w, img_h;
   logic [KER_BITS-1:0] kh, kw, sr, sc;
   logic [PAD_BITS-1:0] pv, ph;
   logic                ceil_on;

   logic [ROW_BITS-1:0] row_ff, rr_ff;
   logic [COL_BITS-1:0] col_ff, cc_ff, c0_ff;
   logic [POS_BITS-1:0] hpos_ff, wpos_ff, oh_ff, ow_ff;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic                rdv_ff;
   logic [DIVR_BITS-1:0] dv_ff, rem_ff;
   logic [AVG_BITS-1:0] dq_ff;
   logic                neg_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                ov_ff, olb_ff, olp_ff;
   logic signed [AVG_BITS-1:0] oavg_ff;

   logic [SAMPLE_BITS-1:0] rd_data;
   logic signed [CRD_BITS-1:0] hs, ws, hend, wend, r_s, c_s, he, we;
   logic [ROW_BITS-1:0] r0;
   logic [COL_BITS-1:0] c0;
   logic last_row, last_col;
   logic [KER_BITS-1:0] dh, dw;
   logic [DIVR_BITS-1:0] divisor;
   logic signed [AVG_BITS:0] scaled;
   logic [DIVR_BITS:0] trial;

   always_comb begin
      img_w = (w_ff == '0) ? DIM_BITS'(1)
            : (w_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : w_ff;
      img_h = (h_ff == '0) ? DIM_BITS'(1)
            : (h_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : h_ff;
      kh = (kh_ff == '0) ? KER_BITS'(1)
         : (kh_ff > KER_BITS'(MAX_KERNEL)) ? KER_BITS'(MAX_KERNEL) : kh_ff;
      kw = (kw_ff == '0) ? KER_BITS'(1)
         : (kw_ff > KER_BITS'(MAX_KERNEL)) ? KER_BITS'(MAX_KERNEL) : kw_ff;
      sr = (sr_ff == '0) ? KER_BITS'(1) : sr_ff;
      sc = (sc_ff == '0) ? KER_BITS'(1) : sc_ff;
      pv = (KER_BITS'(pad_ff[6:4]) < (kh >> 1)) ? pad_ff[6:4] : PAD_BITS'(kh >> 1);
      ph = (pad_ff[3:0] < (kw >> 1)) ? PAD_BITS'(pad_ff[3:0]) : PAD_BITS'(kw >> 1);
      ceil_on = mode_ff[0];

      r_s  = $signed(CRD_BITS'(row_ff));
      c_s  = $signed(CRD_BITS'(col_ff));
      hs   = $signed(CRD_BITS'(oh_ff)) - $signed(CRD_BITS'(pv));
      ws   = $signed(CRD_BITS'(ow_ff)) - $signed(CRD_BITS'(ph));
      hend = hs + $signed(CRD_BITS'(kh)) - CRD_BITS'(1);
      wend = ws + $signed(CRD_BITS'(kw)) - CRD_BITS'(1);
      r0   = (hs < 0) ? '0 : hs[ROW_BITS-1:0];
      c0   = (ws < 0) ? '0 : ws[COL_BITS-1:0];
      last_row = (DIM_BITS'(row_ff) == img_h - DIM_BITS'(1));
      last_col = (DIM_BITS'(col_ff) == img_w - DIM_BITS'(1));

      he = hs + $signed(CRD_BITS'(kh));
      if (he > $signed(CRD_BITS'(img_h)) + $signed(CRD_BITS'(pv))) begin
         he = $signed(CRD_BITS'(img_h)) + $signed(CRD_BITS'(pv));
      end
      we = ws + $signed(CRD_BITS'(kw));
      if (we > $signed(CRD_BITS'(img_w)) + $signed(CRD_BITS'(ph))) begin
         we = $signed(CRD_BITS'(img_w)) + $signed(CRD_BITS'(ph));
      end
      dh = '0;
      dw = '0;
      if (mode_ff[2]) begin
         divisor = (mode_ff[15:8] == '0) ? DIVR_BITS'(1) : mode_ff[15:8];
      end else begin
         if (mode_ff[1]) begin
            dh = KER_BITS'(he - hs);
            dw = KER_BITS'(we - ws);
         end else begin
            dh = KER_BITS'(row_ff - r0 + ROW_BITS'(1));
            dw = KER_BITS'(col_ff - c0 + COL_BITS'(1));
         end
         divisor = DIVR_BITS'(dh) * DIVR_BITS'(dw);
         if (divisor == '0) begin
            divisor = DIVR_BITS'(1);
         end
      end

      scaled = $signed({{(AVG_BITS+1-SUM_BITS){sum_ff[SUM_BITS-1]}}, sum_ff}) <<< FRAC_BITS;
      trial  = {rem_ff, dq_ff[AVG_BITS-1]};

      status.row_hit  = win_ok(oh_ff, img_h, kh, pv, sr, ceil_on) &&
                        (hend == r_s || last_row);
      status.col_hit  = win_ok(ow_ff, img_w, kw, ph, sc, ceil_on) &&
                        (wend == c_s || last_col);
      status.row_more = last_row &&
                        win_ok(oh_ff + POS_BITS'(sr), img_h, kh, pv, sr, ceil_on);
      status.col_more = last_col &&
                        win_ok(ow_ff + POS_BITS'(sc), img_w, kw, ph, sc, ceil_on);
      status.rd_last  = (rr_ff == row_ff) && (cc_ff == col_ff);
      status.div_done = (cnt_ff == CNT_BITS'(AVG_BITS - 1));
      status.out_free = !ov_ff || rsp_ready;
   end

   apool_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LS_DEPTH)) u_line_store (
      .clock (clock),
      .we    (cmd.store),
      .waddr ({row_ff[SLOT_BITS-1:0], col_ff}),
      .wdata (sample),
      .raddr ({rr_ff[SLOT_BITS-1:0], cc_ff}),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= DIM_BITS'(1);
         h_ff    <= DIM_BITS'(1);
         kh_ff   <= KER_BITS'(2);
         kw_ff   <= KER_BITS'(2);
         sr_ff   <= KER_BITS'(2);
         sc_ff   <= KER_BITS'(2);
         pad_ff  <= '0;
         mode_ff <= 16'd2;
         row_ff  <= '0;
         col_ff  <= '0;
         hpos_ff <= '0;
         wpos_ff <= '0;
         rdv_ff  <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         rdv_ff <= cmd.rd_step;
         if (cmd.emit) begin
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               REG_WIDTH:  w_ff    <= csr_data[DIM_BITS-1:0];
               REG_HEIGHT: h_ff    <= csr_data[DIM_BITS-1:0];
               REG_KH:     kh_ff   <= csr_data[KER_BITS-1:0];
               REG_KW:     kw_ff   <= csr_data[KER_BITS-1:0];
               REG_SR:     sr_ff   <= csr_data[KER_BITS-1:0];
               REG_SC:     sc_ff   <= csr_data[KER_BITS-1:0];
               REG_PAD:    pad_ff  <= csr_data[6:0];
               REG_MODE:   mode_ff <= csr_data;
               default:    mode_ff <= mode_ff;
            endcase
            row_ff  <= '0;
            col_ff  <= '0;
            hpos_ff <= '0;
            wpos_ff <= '0;
         end else if (cmd.advance) begin
            if (last_col) begin
               col_ff  <= '0;
               wpos_ff <= '0;
               if (last_row) begin
                  row_ff  <= '0;
                  hpos_ff <= '0;
               end else begin
                  row_ff <= row_ff + ROW_BITS'(1);
                  if ($signed(CRD_BITS'(hpos_ff)) - $signed(CRD_BITS'(pv))
                      + $signed(CRD_BITS'(kh)) - CRD_BITS'(1) <= r_s) begin
                     hpos_ff <= hpos_ff + POS_BITS'(sr);
                  end
               end
            end else begin
               col_ff <= col_ff + COL_BITS'(1);
               if ($signed(CRD_BITS'(wpos_ff)) - $signed(CRD_BITS'(ph))
                   + $signed(CRD_BITS'(kw)) - CRD_BITS'(1) <= c_s) begin
                  wpos_ff <= wpos_ff + POS_BITS'(sc);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_init) begin
         oh_ff <= hpos_ff;
      end else if (cmd.row_step) begin
         oh_ff <= oh_ff + POS_BITS'(sr);
      end
      if (cmd.col_init) begin
         ow_ff <= wpos_ff;
      end else if (cmd.col_step) begin
         ow_ff <= ow_ff + POS_BITS'(sc);
      end
      if (cmd.sum_init) begin
         rr_ff  <= r0;
         cc_ff  <= c0;
         c0_ff  <= c0;
         sum_ff <= '0;
      end else begin
         if (cmd.rd_step) begin
            if (cc_ff == col_ff) begin
               cc_ff <= c0_ff;
               rr_ff <= rr_ff + ROW_BITS'(1);
            end else begin
               cc_ff <= cc_ff + COL_BITS'(1);
            end
         end
         if (rdv_ff) begin
            sum_ff <= sum_ff + SUM_BITS'($signed(rd_data));
         end
      end
      if (cmd.div_init) begin
         neg_ff <= sum_ff[SUM_BITS-1];
         dq_ff  <= sum_ff[SUM_BITS-1] ? AVG_BITS'(-scaled) : AVG_BITS'(scaled);
         rem_ff <= '0;
         dv_ff  <= divisor;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, dv_ff}) begin
            rem_ff <= DIVR_BITS'(trial - {1'b0, dv_ff});
            dq_ff  <= {dq_ff[AVG_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DIVR_BITS-1:0];
            dq_ff  <= {dq_ff[AVG_BITS-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
      if (cmd.emit) begin
         oavg_ff <= neg_ff ? -$signed(dq_ff) : $signed(dq_ff);
         olb_ff  <= !status.col_more && !status.row_more;
         olp_ff  <= !win_ok(oh_ff + POS_BITS'(sr), img_h, kh, pv, sr, ceil_on) &&
                    !win_ok(ow_ff + POS_BITS'(sc), img_w, kw, ph, sc, ceil_on);
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_average       = oavg_ff;
   assign rsp_last_of_burst = olb_ff;
   assign rsp_last_of_plane = olp_ff;
endmodule

[hw/rtl/avg_pool_2d_stream_top.sv]
`timescale 1ns / 1ps
// Streaming 2-D average pooling over one image plane.
// Samples enter on req_chan in raster order; each transfer stores the sample
// in an eight-row line store and emits, on rsp_chan, every window average
// whose last in-image sample this is (zero to 25 results per sample).
// Each result carries the window average with 8 fraction bits, a flag on the
// last result of the sample, and a flag on the final output of the plane.
// Registers must be written by the user through csr_we, csr_index and
// csr_data only while the block is idle; the block does not enforce this.
// Any write restarts the plane at row 0, column 0. A sample that completes
// no window goes from idle through S_ROW, also S_COL when its row ends a
// window but its column does not, and S_NEXT back to idle before the next
// transfer. Each result reads its in-image samples one per cycle from the
// line store's single read port and divides the sum in a bit-serial divider.
// Results leave through an output register, so the next sample is taken
// while the last result waits; a stalled receiver holds the block only when
// a further result is ready to load. Reset restores the default registers
// (1x1 image, 2x2 kernel and stride, no padding, count padding on) and starts
// a new plane; the line store is not cleared.
module avg_pool_2d_stream_top import apool_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   apool_req_if.sink                 req_chan,
   apool_rsp_if.source               rsp_chan,
   input  logic                      csr_we,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);
   cmd_type    cmd;
   status_type status;

   apool_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   apool_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .sample            (req_chan.sample),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_average       (rsp_chan.average),
      .rsp_last_of_burst (rsp_chan.last_of_burst),
      .rsp_last_of_plane (rsp_chan.last_of_plane)
   );
endmodule

[test/avg_pool_2d_stream_top_tb.sv]
`timescale 1ns / 1ps
module avg_pool_2d_stream_top_tb;
   import apool_pkg::*;

   typedef struct {
      logic signed [AVG_BITS-1:0] average;
      logic                       last_of_burst;
      logic                       last_of_plane;
   } pool_result_t;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      bit                            typed;
      logic signed [AVG_BITS-1:0]    average;
   } stim_row_t;

   typedef struct {
      int regs[8];
      int count;
      int fill;
   } phase_t;

   localparam int REG_MASK[8] = '{'h7FF, 'h7FF, 'hF, 'hF, 'hF, 'hF, 'h7F, 'hFFFF};
   localparam int FILL_RANDOM = 0;
   localparam int FILL_MIN    = 1;
   localparam int FILL_MAX    = 2;
   localparam int SETTLE      = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   apool_req_if req_bus ();
   apool_rsp_if rsp_bus ();

   avg_pool_2d_stream_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   int pool_cfg[8] = '{1, 1, 2, 2, 2, 2, 0, 2};
   logic [SAMPLE_BITS-1:0] line_rows [MAX_KERNEL*MAX_WIDTH];
   int row_pos = 0;
   int col_pos = 0;
   pool_result_t pending_averages[$];
   int errors = 0;
   int samples_sent = 0;
   int results_seen = 0;
   int send_idle = 0;
   int recv_stall = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int clip(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int out_positions(input int extent, input int k, input int p,
                                        input int s, input bit ceil_m);
      int n;
      int o;
      n = extent + 2 * p - k;
      if (n < 0) return 0;
      o = (ceil_m ? (n + s - 1) / s : n / s) + 1;
      if (ceil_m && (o - 1) * s >= extent + p) o--;
      return o;
   endfunction

   function automatic void window_averages(input logic signed [SAMPLE_BITS-1:0] s,
                                           ref pool_result_t res[$]);
      int w, h, kh, kw, sr, sc, pv, ph, oh_n, ow_n, r, c;
      int hs, hl, ws, wl, r0, c0, he, we;
      bit ceil_m, cnt_pad, ovr;
      longint sum, dv, q, odiv;
      pool_result_t item;
      w = clip(pool_cfg[REG_WIDTH], 1, MAX_WIDTH);
      h = clip(pool_cfg[REG_HEIGHT], 1, MAX_HEIGHT);
      kh = clip(pool_cfg[REG_KH], 1, MAX_KERNEL);
      kw = clip(pool_cfg[REG_KW], 1, MAX_KERNEL);
      sr = clip(pool_cfg[REG_SR], 1, 15);
      sc = clip(pool_cfg[REG_SC], 1, 15);
      pv = ((pool_cfg[REG_PAD] >> 4) & 7) < kh / 2 ? (pool_cfg[REG_PAD] >> 4) & 7 : kh / 2;
      ph = (pool_cfg[REG_PAD] & 15) < kw / 2 ? pool_cfg[REG_PAD] & 15 : kw / 2;
      ceil_m = pool_cfg[REG_MODE][0];
      cnt_pad = pool_cfg[REG_MODE][1];
      ovr = pool_cfg[REG_MODE][2];
      odiv = (pool_cfg[REG_MODE] >> 8) & 255;
      if (odiv == 0) odiv = 1;
      oh_n = out_positions(h, kh, pv, sr, ceil_m);
      ow_n = out_positions(w, kw, ph, sc, ceil_m);
      if (row_pos >= h || col_pos >= w) begin
         row_pos = 0;
         col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      line_rows[(r % MAX_KERNEL) * MAX_WIDTH + c] = s;
      for (int oh = 0; oh < oh_n; oh++) begin
         hs = oh * sr - pv;
         hl = (hs + kh - 1 < h - 1) ? hs + kh - 1 : h - 1;
         if (hl != r) continue;
         for (int ow = 0; ow < ow_n; ow++) begin
            ws = ow * sc - ph;
            wl = (ws + kw - 1 < w - 1) ? ws + kw - 1 : w - 1;
            if (wl != c) continue;
            r0 = hs > 0 ? hs : 0;
            c0 = ws > 0 ? ws : 0;
            sum = 0;
            for (int rr = r0; rr <= hl; rr++)
               for (int cc = c0; cc <= wl; cc++)
                  sum += longint'($signed(line_rows[(rr % MAX_KERNEL) * MAX_WIDTH + cc]));
            if (ovr) begin
               dv = odiv;
            end else if (cnt_pad) begin
               he = (hs + kh < h + pv) ? hs + kh : h + pv;
               we = (ws + kw < w + ph) ? ws + kw : w + ph;
               dv = longint'(he - hs) * longint'(we - ws);
            end else begin
               dv = longint'(hl - r0 + 1) * longint'(wl - c0 + 1);
            end
            if (dv < 1) dv = 1;
            q = (sum * 256) / dv;
            if (q > 536870911) q = 536870911;
            if (q < -536870912) q = -536870912;
            item.average = q[AVG_BITS-1:0];
            item.last_of_burst = 1'b0;
            item.last_of_plane = (oh == oh_n - 1 && ow == ow_n - 1);
            res.push_back(item);
         end
      end
      if (res.size() > 0) res[res.size()-1].last_of_burst = 1'b1;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit typed,
                              input logic signed [AVG_BITS-1:0] typed_avg);
      pool_result_t res[$];
      pool_result_t item;
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.sample = s;
      do @(posedge clock); while (!req_bus.ready);
      window_averages(s, res);
      if (typed) begin
         item.average = typed_avg;
         item.last_of_burst = 1'b1;
         item.last_of_plane = 1'b1;
         pending_averages.push_back(item);
      end else begin
         foreach (res[i]) pending_averages.push_back(res[i]);
      end
      samples_sent++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic load_config(input int regs[8]);
      while (pending_averages.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_we = 1'b1;
         csr_index = csr_index_type'(i);
         csr_data = regs[i][CSR_DATA_BITS-1:0];
         pool_cfg[i] = regs[i] & REG_MASK[i];
         row_pos = 0;
         col_pos = 0;
         @(negedge clock);
      end
      csr_we = 1'b0;
   endtask

   task automatic run_phase(input phase_t ph, input int idx);
      logic signed [SAMPLE_BITS-1:0] s;
      case (idx % 4)
         0: begin send_idle = 0;  recv_stall = 0;  end
         1: begin send_idle = 47; recv_stall = 0;  end
         2: begin send_idle = 0;  recv_stall = 47; end
         default: begin send_idle = 20; recv_stall = 20; end
      endcase
      load_config(ph.regs);
      for (int i = 0; i < ph.count; i++) begin
         if (ph.fill == FILL_MIN) s = 16'sh8000;
         else if (ph.fill == FILL_MAX) s = 16'sh7FFF;
         else if ($urandom_range(7) == 0) s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         else s = SAMPLE_BITS'($urandom());
         send_sample(s, 1'b0, '0);
      end
   endtask

   always @(negedge clock) begin
      rsp_bus.ready = reset ? 1'b0 : ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      pool_result_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_averages.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_bus.average));
         end else begin
            want = pending_averages.pop_front();
            if (rsp_bus.average !== want.average)
               report_mismatch($sformatf("average %0d, expected %0d",
                                         rsp_bus.average, want.average));
            if (rsp_bus.last_of_burst !== want.last_of_burst)
               report_mismatch($sformatf("last_of_burst %b, expected %b",
                                         rsp_bus.last_of_burst, want.last_of_burst));
            if (rsp_bus.last_of_plane !== want.last_of_plane)
               report_mismatch($sformatf("last_of_plane %b, expected %b",
                                         rsp_bus.last_of_plane, want.last_of_plane));
         end
      end
   end

   initial begin
      stim_row_t table_rows[$];
      phase_t fixed[$];
      phase_t ph;
      int idx;
      int random_sent;
      int unit_cfg[8];
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // A 1x1 image with a 1x1 window returns each sample scaled by 256.
      table_rows = '{
         '{16'sh0000, 1'b1, 30'sd0},
         '{16'sh7FFF, 1'b1, 30'sd8388352},
         '{16'sh8000, 1'b1, -30'sd8388608},
         '{16'sh0001, 1'b1, 30'sd256},
         '{16'shFFFF, 1'b1, -30'sd256},
         '{16'sh5555, 1'b0, '0},
         '{16'shAAAA, 1'b0, '0},
         '{16'sh00FF, 1'b0, '0}
      };
      unit_cfg = '{1, 1, 1, 1, 1, 1, 0, 0};
      load_config(unit_cfg);
      foreach (table_rows[i])
         send_sample(table_rows[i].sample, table_rows[i].typed, table_rows[i].average);

      fixed = '{
         '{'{5, 4, 3, 3, 2, 2, 'h11, 'h0003}, 20, FILL_RANDOM},
         '{'{0, 0, 0, 0, 0, 0, 'h7F, 'h0004}, 4, FILL_RANDOM},
         '{'{2047, 1, 15, 1, 0, 0, 0, 0}, 8, FILL_RANDOM},
         '{'{8, 8, 8, 8, 8, 8, 'h44, 'h0001}, 32, FILL_RANDOM},
         '{'{8, 8, 8, 8, 8, 8, 0, 'h0104}, 64, FILL_MIN},
         '{'{8, 8, 8, 8, 15, 15, 'h7F, 'hFF06}, 64, FILL_MAX},
         '{'{6, 6, 2, 2, 1, 1, 'h11, 'h0002}, 15, FILL_RANDOM},
         '{'{6, 6, 2, 2, 1, 1, 'h11, 'h0002}, 36, FILL_RANDOM}
      };
      idx = 0;
      foreach (fixed[i]) begin
         run_phase(fixed[i], idx);
         idx++;
      end

      random_sent = 0;
      while (random_sent < 20) begin
         ph.regs[REG_WIDTH] = $urandom_range(1, 10);
         ph.regs[REG_HEIGHT] = $urandom_range(1, 10);
         ph.regs[REG_KH] = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
         ph.regs[REG_KW] = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
         ph.regs[REG_SR] = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
         ph.regs[REG_SC] = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
         ph.regs[REG_PAD] = $urandom_range(127);
         ph.regs[REG_MODE] = $urandom_range(65535);
         ph.count = $urandom_range(10, 40);
         ph.fill = FILL_RANDOM;
         run_phase(ph, idx);
         idx++;
         random_sent += ph.count;
      end

      while (pending_averages.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      $display("Streamed %0d samples over %0d register settings; %0d averages checked.",
               samples_sent, idx + 1, results_seen);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/apool_pkg.sv
hw/rtl/apool_ifs.sv
hw/rtl/apool_ram.sv
hw/rtl/apool_ctrl.sv
hw/rtl/apool_dp.sv
hw/rtl/avg_pool_2d_stream_top.sv
test/avg_pool_2d_stream_top_tb.sv
